// ===== rtl/core/cim_pkg.sv =====
package cim_pkg;

   localparam int MAX_ENTRIES   = 16;
   localparam int PATTERN_BYTES = 8;
   localparam int DATA_BYTES    = 8;
   localparam int WORD_BYTES    = 4;

   localparam int ADDR_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int PAT_W   = 8 * PATTERN_BYTES;
   localparam int LEN_W   = $clog2(PATTERN_BYTES + 1);
   localparam int DATA_W  = 8 * DATA_BYTES;
   localparam int SIZE_W  = 4;
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 5;
   localparam int INDEX_W = 4;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_MATCH = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] opcode;
      logic [WORD_W-1:0] mask;
      logic [WORD_W-1:0] value;
      logic [PAT_W-1:0]  pattern;
      logic [LEN_W-1:0]  length;
   } entry_type;

endpackage

// ===== rtl/core/cim_table.sv =====
module cim_table (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [cim_pkg::ADDR_W-1:0] wr_addr,
   input  cim_pkg::entry_type        wr_entry,
   input  logic [cim_pkg::ADDR_W-1:0] rd_addr,
   output cim_pkg::entry_type        rd_entry
);

   cim_pkg::entry_type entries_ff [cim_pkg::MAX_ENTRIES];
   cim_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= entries_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== rtl/core/cim_entry_compare.sv =====
module cim_entry_compare (
   input  cim_pkg::entry_type               entry,
   input  logic [cim_pkg::DATA_W-1:0]       data_bytes,
   input  logic [cim_pkg::SIZE_W-1:0]       data_size,
   output logic                             hit
);

   logic [cim_pkg::DATA_W-1:0] pattern_wide;
   logic [cim_pkg::WORD_W-1:0] word;
   logic                       bytes_equal;
   logic                       long_enough;

   assign pattern_wide = cim_pkg::DATA_W'(entry.pattern);
   assign word         = data_bytes[cim_pkg::WORD_W-1:0];

   // Compare only the bytes below the pattern length.
   always_comb begin
      bytes_equal = 1'b1;
      for (int b = 0; b < cim_pkg::DATA_BYTES; b++) begin
         if (b < int'(entry.length) && data_bytes[8*b +: 8] != pattern_wide[8*b +: 8]) begin
            bytes_equal = 1'b0;
         end
      end
   end

   assign long_enough = 32'(entry.length) <= 32'(data_size);

   always_comb begin
      if (entry.mask != '0) begin
         hit = (32'(data_size) >= 32'(cim_pkg::WORD_BYTES)) &&
               ((word & entry.mask) == entry.value);
      end else begin
         hit = long_enough && bytes_equal;
      end
   end

endmodule

// ===== rtl/core/custom_instruction_matcher_unit.sv =====
// Programmable custom instruction matcher. A write item (cmd 0) stores one table entry
// and returns a result with matched low; a match item (cmd 1) scans entries 0 up to
// min(entry_count, 16) - 1 in order and returns the opcode of the first that hits. The
// scan reads one entry per cycle from the table's registered read port into a single
// compare unit; the result then waits in the result state until the output register is
// free. The block takes one item at a time; it is ready again once the result is in
// the output register. Write entry_count only while the block is idle, and write every
// entry below it before running a match.
module custom_instruction_matcher_unit (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic [cim_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic [31:0]                       req_entry_opcode,
   input  logic [31:0]                       req_entry_mask,
   input  logic [31:0]                       req_entry_value,
   input  logic [63:0]                       req_entry_pattern,
   input  logic [3:0]                        req_entry_pattern_length,
   input  logic [63:0]                       req_data_bytes,
   input  logic [3:0]                        req_data_size,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_matched,
   output logic [31:0]                       rsp_match_opcode,

   input  logic                              csr_write_enable,
   input  logic [cim_pkg::COUNT_W-1:0]       csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type                   state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_matched_ff, rsp_matched_in;
   logic [31:0]                 rsp_opcode_ff, rsp_opcode_in;
   logic                        hit_ff, hit_in;
   logic [31:0]                 opcode_ff, opcode_in;
   logic [cim_pkg::ADDR_W-1:0]  index_ff, index_in;
   logic [cim_pkg::CNT_W-1:0]   limit_ff, limit_in;
   logic [cim_pkg::DATA_W-1:0]  data_ff, data_in;
   logic [cim_pkg::SIZE_W-1:0]  size_ff, size_in;
   logic [cim_pkg::COUNT_W-1:0] entry_count_ff;

   logic                        req_transfer;
   logic                        table_wr_en;
   cim_pkg::entry_type          wr_entry;
   logic [cim_pkg::ADDR_W-1:0]  rd_addr;
   cim_pkg::entry_type          rd_entry;
   logic                        entry_hit;
   logic [cim_pkg::CNT_W-1:0]   index_next;
   logic [cim_pkg::CNT_W-1:0]   scan_limit;
   logic                        out_free;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_transfer = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;

   assign table_wr_en = req_transfer && (req_cmd == cim_pkg::CMD_WRITE) &&
                        (32'(req_entry_index) < 32'(cim_pkg::MAX_ENTRIES));

   always_comb begin
      wr_entry.opcode  = req_entry_opcode;
      wr_entry.mask    = req_entry_mask;
      wr_entry.value   = req_entry_value;
      wr_entry.pattern = req_entry_pattern[cim_pkg::PAT_W-1:0];
      if (32'(req_entry_pattern_length) > 32'(cim_pkg::PATTERN_BYTES)) begin
         wr_entry.length = cim_pkg::LEN_W'(cim_pkg::PATTERN_BYTES);
      end else begin
         wr_entry.length = cim_pkg::LEN_W'(req_entry_pattern_length);
      end
   end

   assign scan_limit = (32'(entry_count_ff) > 32'(cim_pkg::MAX_ENTRIES)) ?
                       cim_pkg::CNT_W'(cim_pkg::MAX_ENTRIES) :
                       cim_pkg::CNT_W'(entry_count_ff);

   assign index_next = cim_pkg::CNT_W'(index_ff) + cim_pkg::CNT_W'(1);

   // Fetch the entry for the next scan cycle: entry 0 on accept, then the one after.
   assign rd_addr = (state_ff == ST_SCAN) ? cim_pkg::ADDR_W'(index_next) : '0;

   cim_table u_table (
      .clock    (clock),
      .wr_en    (table_wr_en),
      .wr_addr  (cim_pkg::ADDR_W'(req_entry_index)),
      .wr_entry (wr_entry),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   cim_entry_compare u_compare (
      .entry      (rd_entry),
      .data_bytes (data_ff),
      .data_size  (size_ff),
      .hit        (entry_hit)
   );

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_matched_in = rsp_matched_ff;
      rsp_opcode_in  = rsp_opcode_ff;
      hit_in         = hit_ff;
      opcode_in      = opcode_ff;
      index_in       = index_ff;
      limit_in       = limit_ff;
      data_in        = data_ff;
      size_in        = size_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               hit_in    = 1'b0;
               opcode_in = '0;
               index_in  = '0;
               data_in   = req_data_bytes;
               limit_in  = scan_limit;
               size_in   = (32'(req_data_size) > 32'(cim_pkg::DATA_BYTES)) ?
                           cim_pkg::SIZE_W'(cim_pkg::DATA_BYTES) : req_data_size;
               if (req_cmd == cim_pkg::CMD_MATCH && scan_limit != '0) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_SCAN: begin
            if (entry_hit) begin
               hit_in    = 1'b1;
               opcode_in = rd_entry.opcode;
               state_in  = ST_RESULT;
            end else if (index_next == limit_ff) begin
               state_in = ST_RESULT;
            end else begin
               index_in = cim_pkg::ADDR_W'(index_next);
            end
         end
         ST_RESULT: begin
            // Hold until the output register is free.
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_matched_in = hit_ff;
               rsp_opcode_in  = opcode_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            entry_count_ff <= csr_write_data;
         end
      end
      rsp_matched_ff <= rsp_matched_in;
      rsp_opcode_ff  <= rsp_opcode_in;
      hit_ff         <= hit_in;
      opcode_ff      <= opcode_in;
      index_ff       <= index_in;
      limit_ff       <= limit_in;
      data_ff        <= data_in;
      size_ff        <= size_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_matched      = rsp_matched_ff;
   assign rsp_match_opcode = rsp_opcode_ff;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_ITEMS  = 1220;

   typedef struct {
      logic        cmd;
      bit [3:0]    slot;
      bit [31:0]   opcode;
      bit [31:0]   mask;
      bit [31:0]   cmp;
      bit [63:0]   pattern;
      bit [3:0]    pat_len;
      bit [63:0]   data;
      bit [3:0]    avail;
   } cim_request_type;

   typedef struct {
      bit          hit;
      bit [31:0]   opcode;
   } cim_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_cmd = cim_pkg::CMD_WRITE;
   logic [cim_pkg::INDEX_W-1:0] req_entry_index = '0;
   logic [31:0]                 req_entry_opcode = '0;
   logic [31:0]                 req_entry_mask = '0;
   logic [31:0]                 req_entry_value = '0;
   logic [63:0]                 req_entry_pattern = '0;
   logic [3:0]                  req_entry_pattern_length = '0;
   logic [63:0]                 req_data_bytes = '0;
   logic [3:0]                  req_data_size = '0;

   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_matched;
   logic [31:0]                 rsp_match_opcode;

   logic                        csr_write_enable = 1'b0;
   logic [cim_pkg::COUNT_W-1:0] csr_write_data = '0;

   // shadow of the match table and the entry count
   bit [31:0] tbl_opcode  [cim_pkg::MAX_ENTRIES];
   bit [31:0] tbl_mask    [cim_pkg::MAX_ENTRIES];
   bit [31:0] tbl_value   [cim_pkg::MAX_ENTRIES];
   bit [63:0] tbl_pattern [cim_pkg::MAX_ENTRIES];
   int        tbl_len     [cim_pkg::MAX_ENTRIES];
   int        active_count = 0;

   cim_outcome_type expected_outcomes[$];
   int              mismatch_count = 0;
   int              idle_cycles = 0;

   bit           flow_steady = 1'b0;
   bit           valid_held = 1'b0;
   int           burst_left = 0;
   bit [31:0]    stall_pattern = '1;
   bit [4:0]     stall_step = '0;

   custom_instruction_matcher_unit i_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_cmd                  (req_cmd),
      .req_entry_index          (req_entry_index),
      .req_entry_opcode         (req_entry_opcode),
      .req_entry_mask           (req_entry_mask),
      .req_entry_value          (req_entry_value),
      .req_entry_pattern        (req_entry_pattern),
      .req_entry_pattern_length (req_entry_pattern_length),
      .req_data_bytes           (req_data_bytes),
      .req_data_size            (req_data_size),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_matched              (rsp_matched),
      .rsp_match_opcode         (rsp_match_opcode),
      .csr_write_enable         (csr_write_enable),
      .csr_write_data           (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: reload a random stall pattern when the 5-bit step counter wraps, ready on 3 of 4 bits
   always @(posedge clock) begin
      stall_step <= stall_step + 5'd1;
      if (stall_step == 5'd0) begin
         stall_pattern <= $urandom;
      end else begin
         stall_pattern <= stall_pattern >> 1;
      end
      rsp_ready <= flow_steady || stall_pattern[0] || stall_pattern[1];
   end

   always @(posedge clock) begin
      cim_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none, actual matched %0b opcode %h",
                     $time, rsp_matched, rsp_match_opcode);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_matched !== want.hit) begin
               mismatch_count++;
               $display("%0t: matched expected %0b actual %0b",
                        $time, want.hit, rsp_matched);
            end
            if (rsp_match_opcode !== want.opcode) begin
               mismatch_count++;
               $display("%0t: match_opcode expected %h actual %h",
                        $time, want.opcode, rsp_match_opcode);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic bit [63:0] prefix_mask(int len);
      if (len >= cim_pkg::PATTERN_BYTES) return '1;
      return (64'd1 << (8 * len)) - 64'd1;
   endfunction

   // update the shadow table on a write, scan it on a match
   function automatic cim_outcome_type predict_outcome(cim_request_type r);
      cim_outcome_type o;
      int              avail;
      int              scan;
      bit              hit;
      o.hit = 1'b0;
      o.opcode = '0;
      if (r.cmd == cim_pkg::CMD_WRITE) begin
         tbl_opcode[r.slot]  = r.opcode;
         tbl_mask[r.slot]    = r.mask;
         tbl_value[r.slot]   = r.cmp;
         tbl_pattern[r.slot] = r.pattern;
         tbl_len[r.slot]     = (r.pat_len > cim_pkg::PATTERN_BYTES) ?
                               cim_pkg::PATTERN_BYTES : int'(r.pat_len);
      end else begin
         avail = (r.avail > cim_pkg::DATA_BYTES) ? cim_pkg::DATA_BYTES : int'(r.avail);
         scan  = (active_count > cim_pkg::MAX_ENTRIES) ? cim_pkg::MAX_ENTRIES : active_count;
         for (int k = 0; k < scan && !o.hit; k++) begin
            if (tbl_mask[k] != 0) begin
               hit = (avail >= cim_pkg::WORD_BYTES) &&
                     ((r.data[31:0] & tbl_mask[k]) == tbl_value[k]);
            end else begin
               hit = (tbl_len[k] <= avail) &&
                     (((r.data ^ tbl_pattern[k]) & prefix_mask(tbl_len[k])) == 0);
            end
            if (hit) begin
               o.hit = 1'b1;
               o.opcode = tbl_opcode[k];
            end
         end
      end
      return o;
   endfunction

   function automatic cim_request_type noise_fields();
      cim_request_type r;
      r.cmd     = 1'($urandom_range(0, 1));
      r.slot    = 4'($urandom);
      r.opcode  = $urandom;
      r.mask    = $urandom;
      r.cmp     = $urandom;
      r.pattern = {$urandom, $urandom};
      r.pat_len = 4'($urandom);
      r.data    = {$urandom, $urandom};
      r.avail   = 4'($urandom);
      return r;
   endfunction

   function automatic cim_request_type entry_write(bit [3:0] slot, bit [31:0] opcode,
                                                  bit [31:0] mask, bit [31:0] cmp,
                                                  bit [63:0] pattern, bit [3:0] pat_len);
      cim_request_type r;
      r = noise_fields();
      r.cmd     = cim_pkg::CMD_WRITE;
      r.slot    = slot;
      r.opcode  = opcode;
      r.mask    = mask;
      r.cmp     = cmp;
      r.pattern = pattern;
      r.pat_len = pat_len;
      return r;
   endfunction

   function automatic cim_request_type match_item(bit [63:0] data, bit [3:0] avail);
      cim_request_type r;
      r = noise_fields();
      r.cmd   = cim_pkg::CMD_MATCH;
      r.data  = data;
      r.avail = avail;
      return r;
   endfunction

   // mostly well-formed entries: value inside the mask, pattern of 1 to 8 bytes
   function automatic cim_request_type random_entry(bit [3:0] slot);
      cim_request_type r;
      int              kind;
      r = noise_fields();
      r.cmd  = cim_pkg::CMD_WRITE;
      r.slot = slot;
      kind   = $urandom_range(0, 19);
      if (kind < 10) begin
         r.mask = ($urandom_range(0, 1) == 0) ? ($urandom & $urandom) : $urandom;
         if (r.mask == 0) r.mask = 32'h1 << $urandom_range(0, 31);
         if (kind != 0) r.cmp = r.cmp & r.mask;
      end else begin
         r.mask = '0;
         if (kind < 19) begin
            r.pat_len = 4'($urandom_range(1, cim_pkg::PATTERN_BYTES));
         end
      end
      return r;
   endfunction

   function automatic cim_request_type random_item();
      cim_request_type r;
      int              scan;
      int              k;
      bit [63:0]       keep;
      scan = (active_count > cim_pkg::MAX_ENTRIES) ? cim_pkg::MAX_ENTRIES : active_count;
      if ($urandom_range(0, 9) < 3) return random_entry(4'($urandom));
      r = noise_fields();
      r.cmd = cim_pkg::CMD_MATCH;
      if (scan > 0 && $urandom_range(0, 9) < 6) begin
         // aim at one entry: copy its compared bits, randomize the rest
         k = $urandom_range(0, scan - 1);
         if (tbl_mask[k] != 0) begin
            r.data[31:0] = (tbl_value[k] & tbl_mask[k]) | (r.data[31:0] & ~tbl_mask[k]);
            r.avail = 4'($urandom_range(cim_pkg::WORD_BYTES, 15));
         end else begin
            keep = prefix_mask(tbl_len[k]);
            r.data = (tbl_pattern[k] & keep) | (r.data & ~keep);
            r.avail = 4'($urandom_range(tbl_len[k], 15));
         end
      end
      return r;
   endfunction

   task automatic drop_valid();
      if (valid_held) begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
      end
   endtask

   task automatic send_item(input cim_request_type r);
      req_valid                <= 1'b1;
      req_cmd                  <= r.cmd;
      req_entry_index          <= r.slot;
      req_entry_opcode         <= r.opcode;
      req_entry_mask           <= r.mask;
      req_entry_value          <= r.cmp;
      req_entry_pattern        <= r.pattern;
      req_entry_pattern_length <= r.pat_len;
      req_data_bytes           <= r.data;
      req_data_size            <= r.avail;
      valid_held = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_outcomes.insert(expected_outcomes.size(), predict_outcome(r));
      // end of burst: drop valid and idle before the next burst
      if (!flow_steady) begin
         if (burst_left == 0) begin
            drop_valid();
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain_results();
      drop_valid();
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_entry_count(input int count);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= cim_pkg::COUNT_W'(count);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_count = count;
   endtask

   // fill every slot so that any entry count is safe to scan
   task automatic test_table_load();
      send_item(entry_write(4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hDEAD_BEEF, '0, 4'd0));
      send_item(entry_write(4'd1, 32'h0000_0001, 32'h0, 32'h0, '1, 4'd15));
      send_item(entry_write(4'd2, 32'h0000_0002, 32'h0000_007F, 32'h0000_000B, '0, 4'd0));
      send_item(entry_write(4'd3, 32'h0000_0000, 32'h0, 32'h0, 64'hA5, 4'd1));
      send_item(entry_write(4'd4, 32'h8000_0004, 32'h8000_0000, 32'h8000_0000, '0, 4'd8));
      for (int s = 5; s < cim_pkg::MAX_ENTRIES; s++) begin
         send_item(random_entry(4'(s)));
      end
   endtask

   task automatic test_match_rules();
      program_entry_count(cim_pkg::MAX_ENTRIES);
      send_item(match_item(64'h1234_5678_DEAD_BEEF, 4'd4));
      send_item(match_item(64'h0000_0000_DEAD_BEEF, 4'd3));
      send_item(match_item('1, 4'd8));
      send_item(match_item('1, 4'd7));
      send_item(match_item('1, 4'd15));
      send_item(match_item('0, 4'd0));
      send_item(match_item(64'hFFFF_FF00_0000_000B, 4'd4));
      send_item(match_item(64'h0000_0000_0000_00A5, 4'd1));
   endtask

   task automatic test_count_limits();
      program_entry_count(0);
      send_item(match_item(64'h0000_0000_DEAD_BEEF, 4'd8));
      program_entry_count(31);
      send_item(match_item(64'h0000_0000_8000_0000, 4'd4));
      // empty pattern in the last slot hits anything that reaches it
      send_item(entry_write(4'd15, 32'h0F0F_0F0F, 32'h0, 32'h0, '1, 4'd0));
      send_item(match_item(64'h0000_0000_0000_0011, 4'd0));
      program_entry_count(cim_pkg::MAX_ENTRIES);
      send_item(match_item(64'h0000_0000_0000_0011, 4'd2));
   endtask

   task automatic test_random_traffic(input int total);
      int settings[10];
      settings = '{16, 1, 31, 8, 0, 16, 17, 4, 12, 16};
      for (int p = 0; p < 10; p++) begin
         program_entry_count(settings[p]);
         flow_steady = (p % 4 == 2);
         for (int n = 0; n < total / 10; n++) begin
            send_item(random_item());
            if ($urandom_range(0, 99) == 0) drain_results();
         end
      end
      flow_steady = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_table_load();
      test_match_rules();
      test_count_limits();
      test_random_traffic(RANDOM_ITEMS);
      drain_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
